>>> rtl/lrs_pkg.sv
// Shared types and constants for the logistic regression scorer.
package lrs_pkg;

    localparam int ValW               = 16;
    localparam int IdxW               = 6;
    localparam int StoreDepth         = 64;
    localparam int AccW               = 40;
    localparam int ProdW              = 32;
    localparam int ProbW              = 16;
    localparam int MaxFeaturesDefault = 64;
    localparam int QueueDepth         = 4;

    // Operation codes of the input channel.
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_FEATURE = 1'b1;

    // Clamp of the dot product, plus or minus 8 in Q16.16.
    localparam logic signed [AccW-1:0] ClampPos = AccW'(524288);
    localparam logic signed [AccW-1:0] ClampNeg = -AccW'(524288);

    // Reciprocals for the divisions by 6 and by 24, both scaled by 2^20.
    localparam logic [31:0] RecipSix       = 32'd174763;
    localparam logic [31:0] RecipTwentyFour = 32'd43691;
    localparam int          RecipShift     = 20;

    typedef enum logic [1:0] {
        K_LOAD = 2'b00,
        K_FEAT = 2'b01,
        K_LAST = 2'b10
    } t_kind;

    typedef struct packed {
        t_kind                   kind;
        logic [IdxW-1:0]         index;
        logic signed [ValW-1:0]  value;
    } t_item;

    typedef struct packed {
        logic                    valid;
        logic signed [AccW-1:0]  dot;
        logic                    overflow;
    } t_score_req;

    typedef struct packed {
        logic                    valid;
        logic [ProbW-1:0]        probability;
        logic                    overflow;
    } t_score_rsp;

endpackage

>>> rtl/logistic_regression_scorer_top.sv
// Top level of the logistic regression scorer.
//
// Input channel: i_valid / o_stall with i_operation, i_weight_index, i_value and
// i_last_feature. A transfer happens on a rising edge with i_valid high and
// o_stall low. Operation 0 writes i_value into the weight store at
// i_weight_index; operation 1 presents the next feature of the current vector.
// Output channel: o_valid / i_stall with o_probability (unsigned Q0.16) and
// o_overflow; one result per feature marked last.
// Weight loads and features are taken one per cycle while o_stall is low. After a
// last feature the execution side stops draining its four-entry queue until that
// vector's score is in the output register. The sigmoid unit works on each score
// in order: it takes the request, runs the series, performs eight squarings, sets
// up the divider, runs seventeen restoring-divide steps and hands the result over,
// all on one shared multiplier.
// Reset (synchronous, active low) clears the accumulator, the position, the
// overflow flag, the queue and all valid bits; the weight store is not cleared
// and every weight used must be loaded first.
// While i_stall is high the result holds in the output register, and input
// transfers continue until the queue and input stage are full.
module logistic_regression_scorer_top
    import lrs_pkg::*;
#(
    parameter int MAX_FEATURES = MaxFeaturesDefault
)
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_operation,
    input  logic [IdxW-1:0]        i_weight_index,
    input  logic signed [ValW-1:0] i_value,
    input  logic                   i_last_feature,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [ProbW-1:0]       o_probability,
    output logic                   o_overflow
);

    logic        w_push;
    t_item       w_front_item;
    logic        w_full;
    logic        w_q_valid;
    t_item       w_q_item;
    logic        w_pop;
    logic        w_take;
    t_score_req  w_req;
    t_score_rsp  w_rsp;

    logic             r_out_valid;
    logic [ProbW-1:0] r_out_prob;
    logic             r_out_ovf;

    lrs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_weight_index (i_weight_index),
        .i_value        (i_value),
        .i_last_feature (i_last_feature),
        .o_push         (w_push),
        .o_item         (w_front_item),
        .i_full         (w_full)
    );

    lrs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_pop)
    );

    lrs_back #(
        .MAX_FEATURES (MAX_FEATURES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_q_valid),
        .i_item    (w_q_item),
        .o_pop     (w_pop),
        .i_release (w_take),
        .o_req     (w_req)
    );

    lrs_sigmoid u_sigmoid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp),
        .i_take  (w_take)
    );

    assign w_take = w_rsp.valid && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_prob <= w_rsp.probability;
            r_out_ovf  <= w_rsp.overflow;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_probability = r_out_prob;
    assign o_overflow    = r_out_ovf;

endmodule

>>> rtl/lrs_front.sv
// Input stage: takes items from the input channel and classifies them.
module lrs_front
    import lrs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_operation,
    input  logic [IdxW-1:0]        i_weight_index,
    input  logic signed [ValW-1:0] i_value,
    input  logic                   i_last_feature,
    output logic                   o_push,
    output t_item                  o_item,
    input  logic                   i_full
);

    logic  r_valid;
    t_item r_item;
    t_item w_item;
    logic  w_accept;

    always_comb begin
        w_item.index = i_weight_index;
        w_item.value = i_value;
        if (i_operation == OP_LOAD) begin
            w_item.kind = K_LOAD;
        end else if (i_last_feature) begin
            w_item.kind = K_LAST;
        end else begin
            w_item.kind = K_FEAT;
        end
    end

    assign o_push   = r_valid && !i_full;
    assign o_stall  = r_valid && i_full;
    assign w_accept = i_valid && !o_stall;
    assign o_item   = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= w_item;
        end
    end

endmodule

>>> rtl/lrs_queue.sv
// Short queue between the front and the back of the scorer.
module lrs_queue
    import lrs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);

    localparam int PtrW = $clog2(QueueDepth);
    localparam int CntW = $clog2(QueueDepth + 1);

    t_item             r_slots [QueueDepth];
    logic [PtrW-1:0]   r_wr_ptr;
    logic [PtrW-1:0]   r_rd_ptr;
    logic [CntW-1:0]   r_count;

    assign o_full  = (r_count == CntW'(QueueDepth));
    assign o_valid = (r_count != '0);
    assign o_item  = r_slots[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PtrW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PtrW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CntW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CntW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_item;
        end
    end

endmodule

>>> rtl/lrs_back.sv
// Execution side: weight store, multiply-accumulate pipeline and vector bookkeeping.
module lrs_back
    import lrs_pkg::*;
#(
    parameter int MAX_FEATURES = MaxFeaturesDefault
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_item      i_item,
    output logic       o_pop,
    input  logic       i_release,
    output t_score_req o_req
);

    localparam int FeatLimit = (MAX_FEATURES < StoreDepth) ? MAX_FEATURES : StoreDepth;
    localparam int PosW      = $clog2(FeatLimit + 1);

    logic signed [ValW-1:0]  r_weights [StoreDepth];

    logic                    r_hold;
    logic [PosW-1:0]         r_pos;
    logic                    r_ovf_seen;

    logic                    r_s1_valid;
    logic                    r_s1_add;
    logic                    r_s1_last;
    logic                    r_s1_ovf;
    logic signed [ValW-1:0]  r_s1_val;
    logic signed [ValW-1:0]  r_s1_w;

    logic                    r_s2_valid;
    logic                    r_s2_last;
    logic                    r_s2_ovf;
    logic signed [ProdW-1:0] r_s2_prod;

    logic signed [AccW-1:0]  r_acc;
    logic                    r_req_valid;
    logic signed [AccW-1:0]  r_req_dot;
    logic                    r_req_ovf;

    logic                    w_feature;
    logic                    w_last;
    logic                    w_in_range;
    logic [IdxW-1:0]         w_rd_idx;
    logic signed [AccW-1:0]  w_sum;

    assign o_pop      = i_valid && !r_hold;
    assign w_feature  = o_pop && (i_item.kind != K_LOAD);
    assign w_last     = o_pop && (i_item.kind == K_LAST);
    assign w_in_range = (r_pos < PosW'(FeatLimit));
    assign w_rd_idx   = IdxW'(r_pos);
    assign w_sum      = r_acc + AccW'(r_s2_prod);

    assign o_req.valid    = r_req_valid;
    assign o_req.dot      = r_req_dot;
    assign o_req.overflow = r_req_ovf;

    // Weight store: writes from load items, registered read at the current position.
    always_ff @(posedge i_clk) begin
        if (o_pop && (i_item.kind == K_LOAD)) begin
            r_weights[i_item.index] <= i_item.value;
        end
        r_s1_w <= r_weights[w_rd_idx];
    end

    // Once a vector's last feature is taken, nothing more is popped until its
    // score has left the sigmoid unit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold     <= 1'b0;
            r_pos      <= '0;
            r_ovf_seen <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_req_valid <= 1'b0;
            r_acc      <= '0;
        end else begin
            if (w_last) begin
                r_hold <= 1'b1;
            end else if (i_release) begin
                r_hold <= 1'b0;
            end

            if (w_last) begin
                r_pos      <= '0;
                r_ovf_seen <= 1'b0;
            end else if (w_feature) begin
                if (w_in_range) begin
                    r_pos <= r_pos + PosW'(1);
                end else begin
                    r_ovf_seen <= 1'b1;
                end
            end

            r_s1_valid  <= w_feature;
            r_s2_valid  <= r_s1_valid;
            r_req_valid <= r_s2_valid && r_s2_last;

            if (r_s2_valid) begin
                if (r_s2_last) begin
                    r_acc <= '0;
                end else begin
                    r_acc <= w_sum;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_add  <= w_in_range;
        r_s1_last <= (i_item.kind == K_LAST);
        r_s1_ovf  <= r_ovf_seen || !w_in_range;
        r_s1_val  <= i_item.value;

        r_s2_last <= r_s1_last;
        r_s2_ovf  <= r_s1_ovf;
        if (r_s1_add) begin
            r_s2_prod <= ProdW'(r_s1_val) * ProdW'(r_s1_w);
        end else begin
            r_s2_prod <= '0;
        end

        if (r_s2_valid && r_s2_last) begin
            r_req_dot <= w_sum;
            r_req_ovf <= r_s2_ovf;
        end
    end

endmodule

>>> rtl/lrs_sigmoid.sv
// Sequenced sigmoid unit: series for exp, repeated squaring and a restoring divide.
module lrs_sigmoid
    import lrs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_score_req i_req,
    output t_score_rsp o_rsp,
    input  logic       i_take
);

    localparam int QW   = ProbW + 1;
    localparam int CntW = $clog2(QW);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_T2    = 12'b0000_0000_0010,
        S_T3    = 12'b0000_0000_0100,
        S_T4    = 12'b0000_0000_1000,
        S_D6    = 12'b0000_0001_0000,
        S_D24   = 12'b0000_0010_0000,
        S_SUM   = 12'b0000_0100_0000,
        S_SQM   = 12'b0000_1000_0000,
        S_SQR   = 12'b0001_0000_0000,
        S_DINIT = 12'b0010_0000_0000,
        S_DIV   = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } t_sig_state;

    t_sig_state             r_state;
    t_sig_state             n_state;

    logic                   r_neg;
    logic                   r_ovf;
    logic [26:0]            r_t;
    logic [21:0]            r_t2;
    logic [16:0]            r_t3;
    logic [11:0]            r_t4;
    logic [13:0]            r_q6;
    logic [31:0]            r_e;
    logic [63:0]            r_mul;
    logic [CntW-1:0]        r_cnt;
    logic [32:0]            r_d;
    logic [33:0]            r_rem;
    logic [QW-1:0]          r_nlo;
    logic [QW-1:0]          r_q;

    logic [31:0]            w_a;
    logic [31:0]            w_b;
    logic [31:0]            w_sh31;
    logic signed [AccW-1:0] w_clamped;
    logic [19:0]            w_x;
    logic [32:0]            w_e_sum;
    logic [63:0]            w_round;
    logic [32:0]            w_d;
    logic [47:0]            w_num;
    logic [33:0]            w_trial;
    logic                   w_ge;

    assign w_sh31 = r_mul[62:31];

    always_comb begin
        if (i_req.dot > ClampPos) begin
            w_clamped = ClampPos;
        end else if (i_req.dot < ClampNeg) begin
            w_clamped = ClampNeg;
        end else begin
            w_clamped = i_req.dot;
        end
        if (w_clamped[AccW-1]) begin
            w_x = 20'(-w_clamped);
        end else begin
            w_x = 20'(w_clamped);
        end
    end

    // exp(-t) ~ 1 - t + t^2/2 - t^3/6 + t^4/24, all in Q1.31.
    assign w_e_sum = 33'h0_8000_0000 - 33'(r_t) + 33'(r_t2 >> 1) - 33'(r_q6)
                   + 33'(r_mul[RecipShift+6:RecipShift]);
    assign w_round = r_mul + 64'h0000_0000_4000_0000;

    assign w_d   = 33'(r_e) + 33'h0_8000_0000;
    assign w_num = (r_neg ? {r_e, 16'h0000} : 48'h8000_0000_0000) + 48'(w_d >> 1);

    assign w_trial = {r_rem[32:0], r_nlo[QW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_d});

    always_comb begin
        w_a = '0;
        w_b = '0;
        unique case (r_state)
            S_T2: begin
                w_a = 32'(r_t);
                w_b = 32'(r_t);
            end
            S_T3: begin
                w_a = 32'(w_sh31[21:0]);
                w_b = 32'(r_t);
            end
            S_T4: begin
                w_a = 32'(w_sh31[16:0]);
                w_b = 32'(r_t);
            end
            S_D6: begin
                w_a = 32'(r_t3);
                w_b = RecipSix;
            end
            S_D24: begin
                w_a = 32'(r_t4);
                w_b = RecipTwentyFour;
            end
            S_SQM: begin
                w_a = r_e;
                w_b = r_e;
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_req.valid) n_state = S_T2;
            S_T2:    n_state = S_T3;
            S_T3:    n_state = S_T4;
            S_T4:    n_state = S_D6;
            S_D6:    n_state = S_D24;
            S_D24:   n_state = S_SUM;
            S_SUM:   n_state = S_SQM;
            S_SQM:   n_state = S_SQR;
            S_SQR:   n_state = (r_cnt == CntW'(7)) ? S_DINIT : S_SQM;
            S_DINIT: n_state = S_DIV;
            S_DIV:   n_state = (r_cnt == CntW'(QW - 1)) ? S_DONE : S_DIV;
            S_DONE:  if (i_take) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mul <= 64'(w_a) * 64'(w_b);
        unique case (r_state)
            S_IDLE: begin
                r_neg <= i_req.dot[AccW-1];
                r_ovf <= i_req.overflow;
                r_t   <= {w_x, 7'b000_0000};
            end
            S_T3: r_t2 <= w_sh31[21:0];
            S_T4: r_t3 <= w_sh31[16:0];
            S_D6: r_t4 <= w_sh31[11:0];
            S_D24: r_q6 <= r_mul[RecipShift+13:RecipShift];
            S_SUM: begin
                r_e   <= w_e_sum[31:0];
                r_cnt <= '0;
            end
            S_SQR: begin
                r_e   <= w_round[62:31];
                r_cnt <= r_cnt + CntW'(1);
            end
            S_DINIT: begin
                // Remainder starts at the top numerator bits: final square if dot < 0, else 1.
                r_d   <= w_d;
                r_rem <= 34'(w_num[47:QW]);
                r_nlo <= w_num[QW-1:0];
                r_q   <= '0;
                r_cnt <= '0;
            end
            S_DIV: begin
                r_nlo <= {r_nlo[QW-2:0], 1'b0};
                r_cnt <= r_cnt + CntW'(1);
                if (w_ge) begin
                    r_rem <= w_trial - {1'b0, r_d};
                    r_q   <= {r_q[QW-2:0], 1'b1};
                end else begin
                    r_rem <= w_trial;
                    r_q   <= {r_q[QW-2:0], 1'b0};
                end
            end
            default: begin
            end
        endcase
    end

    assign o_rsp.valid       = (r_state == S_DONE);
    assign o_rsp.probability = r_q[QW-1] ? {ProbW{1'b1}} : r_q[ProbW-1:0];
    assign o_rsp.overflow    = r_ovf;

endmodule
